[rtl/bkry_pkg.sv]
// Package for the bakery ticket lock arbiter: transaction types, action codes and states.
`timescale 1ns / 1ps
`default_nettype none
package bkry_pkg;

  localparam logic ACT_LOCK   = 1'b0;
  localparam logic ACT_UNLOCK = 1'b1;

  typedef struct packed {
    logic       action;
    logic [5:0] requester_id;
  } bkry_req_t;

  typedef struct packed {
    logic [15:0] ticket_given;
    logic [5:0]  holder_id;
    logic        holder_valid;
    logic        ticket_overflow;
  } bkry_res_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } bkry_state_t;

endpackage
`default_nettype wire

[rtl/bkry_cell.sv]
// One ticket cell: holds a requester's ticket and folds it into the running max and min links.
`timescale 1ns / 1ps
`default_nettype none
module bkry_cell
  import bkry_pkg::*;
#(
  parameter int TICKET_BITS = 16,
  parameter int ID_BITS     = 6,
  parameter int CELL_ID     = 0
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   wr_en,
  input  wire logic [TICKET_BITS-1:0] wr_value,
  input  wire logic [TICKET_BITS-1:0] max_in,
  input  wire logic                   min_vld_in,
  input  wire logic [TICKET_BITS-1:0] min_in,
  input  wire logic [ID_BITS-1:0]     min_id_in,
  output logic      [TICKET_BITS-1:0] max_out,
  output logic                        min_vld_out,
  output logic      [TICKET_BITS-1:0] min_out,
  output logic      [ID_BITS-1:0]     min_id_out
);

  logic [TICKET_BITS-1:0] ticket;
  logic                   take_own;

  assign take_own = (ticket != '0) && (!min_vld_in || (ticket < min_in));

  always_ff @(posedge clk) begin
    if (rst) begin
      ticket      <= '0;
      max_out     <= '0;
      min_vld_out <= 1'b0;
    end else begin
      if (wr_en) begin
        ticket <= wr_value;
      end
      max_out     <= (ticket > max_in) ? ticket : max_in;
      min_vld_out <= min_vld_in || (ticket != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (take_own) begin
      min_out    <= ticket;
      min_id_out <= ID_BITS'(CELL_ID);
    end else begin
      min_out    <= min_in;
      min_id_out <= min_id_in;
    end
  end

endmodule
`default_nettype wire

[rtl/bakery_ticket_lock_arbiter.sv]
// Top level of the bakery ticket lock arbiter: control sequencer and the row of ticket cells.
// A new transaction is taken only once the previous one has finished; the max and min links ripple
// through the row of REQUESTERS registered cells, one cell per cycle.
// Reset clears every ticket and the max and min-valid links; the first transaction may follow directly.
// Results are strobed for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module bakery_ticket_lock_arbiter
  import bkry_pkg::*;
#(
  parameter int REQUESTERS  = 64,
  parameter int TICKET_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire bkry_req_t req,
  output logic           busy,
  output logic           done,
  output bkry_res_t      res
);

  localparam int ID_BITS  = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
  localparam int CNT_BITS = $clog2(REQUESTERS + 1);
  localparam logic [TICKET_BITS-1:0] TICKET_TOP = {TICKET_BITS{1'b1}};

  logic [TICKET_BITS-1:0] max_link    [REQUESTERS+1];
  logic                   min_vld_link[REQUESTERS+1];
  logic [TICKET_BITS-1:0] min_link    [REQUESTERS+1];
  logic [ID_BITS-1:0]     min_id_link [REQUESTERS+1];

  bkry_state_t           state;
  bkry_state_t           state_next;
  logic [CNT_BITS-1:0]   cnt;
  logic                  accept;
  logic                  finish;
  logic                  in_range;
  logic                  saturated;
  logic [TICKET_BITS-1:0] given;
  logic [TICKET_BITS-1:0] wr_value;
  logic [TICKET_BITS+15:0] given_ext;
  logic [ID_BITS+5:0]     holder_ext;
  logic [15:0]           given_q;
  logic                  ovf_q;

  assign max_link[0]     = '0;
  assign min_vld_link[0] = 1'b0;
  assign min_link[0]     = '0;
  assign min_id_link[0]  = '0;

  assign in_range  = 32'(req.requester_id) < 32'(REQUESTERS);
  assign saturated = max_link[REQUESTERS] == TICKET_TOP;
  assign given     = saturated ? TICKET_TOP : max_link[REQUESTERS] + TICKET_BITS'(1);
  assign wr_value  = (req.action == ACT_LOCK) ? given : '0;
  assign given_ext = {16'b0, given};
  assign holder_ext = {6'b0, min_id_link[REQUESTERS]};

  for (genvar k = 0; k < REQUESTERS; k++) begin : g_cell
    logic wr_en;
    assign wr_en = accept && in_range && (32'(req.requester_id) == 32'(k));
    bkry_cell #(
      .TICKET_BITS(TICKET_BITS),
      .ID_BITS    (ID_BITS),
      .CELL_ID    (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .wr_en      (wr_en),
      .wr_value   (wr_value),
      .max_in     (max_link[k]),
      .min_vld_in (min_vld_link[k]),
      .min_in     (min_link[k]),
      .min_id_in  (min_id_link[k]),
      .max_out    (max_link[k+1]),
      .min_vld_out(min_vld_link[k+1]),
      .min_out    (min_link[k+1]),
      .min_id_out (min_id_link[k+1])
    );
  end

  always_comb begin
    state_next = state;
    accept     = 1'b0;
    finish     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          accept     = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt == CNT_BITS'(REQUESTERS)) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = state != ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
      if (accept) begin
        cnt <= '0;
      end else if (state == ST_RUN) begin
        cnt <= cnt + CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_range && (req.action == ACT_LOCK)) begin
        given_q <= given_ext[15:0];
        ovf_q   <= saturated;
      end else begin
        given_q <= '0;
        ovf_q   <= 1'b0;
      end
    end
    if (finish) begin
      res.ticket_given    <= given_q;
      res.ticket_overflow <= ovf_q;
      res.holder_valid    <= min_vld_link[REQUESTERS];
      res.holder_id       <= min_vld_link[REQUESTERS] ? holder_ext[5:0] : 6'b0;
    end
  end

endmodule
`default_nettype wire
